FILE: rtl/fvn_pkg.sv
// Package for the fractal value noise unit: field widths, hash constants and the
// raised-cosine blend table, which is built once at elaboration.
// Depends on nothing.
package fvn_pkg;

  localparam int COORD_W          = 40;
  localparam int SEED_W           = 32;
  localparam int CFG_W            = 4;
  localparam int COORD_FRAC_BITS  = 16;
  localparam int VALUE_BITS       = 16;
  localparam int OUT_W            = VALUE_BITS + 1;
  localparam int CURVE_TABLE_BITS = 8;
  localparam int CURVE_BITS       = 16;
  localparam int CURVE_ENTRIES    = 2 ** CURVE_TABLE_BITS;
  localparam int SMOOTH_W         = VALUE_BITS + 4;
  localparam int HASH_W           = 32;
  localparam int LATTICE_PTS      = 16;

  localparam logic [HASH_W-1:0] HASH_X = 32'd374761393;
  localparam logic [HASH_W-1:0] HASH_Y = 32'd668265263;
  localparam logic [HASH_W-1:0] HASH_S = 32'd982451653;
  localparam logic [HASH_W-1:0] HASH_M = 32'd1274126177;
  localparam int                HASH_XSHIFT = 13;

  localparam logic [CFG_W-1:0] OCTAVE_RESET = 4'd6;
  localparam logic [63:0]      HALF_PI_Q30  = 64'd1686629713;

  typedef logic [HASH_W-1:0]     hash_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [SMOOTH_W-1:0]   smooth_t;
  typedef logic [CURVE_BITS:0]   curve_t;
  typedef logic [CURVE_ENTRIES-1:0][CURVE_BITS:0] curve_table_t;

  // sin^2 sampled over a quarter period, Q30 Taylor series, rounded to CURVE_BITS
  function automatic curve_table_t build_curve_table();
    curve_table_t tbl;
    logic [63:0]  phi;
    logic [63:0]  p2;
    logic [63:0]  term;
    logic [63:0]  s;
    for (int k = 0; k < CURVE_ENTRIES; k++) begin
      phi  = (HALF_PI_Q30 * 64'(k)) >> CURVE_TABLE_BITS;
      p2   = (phi * phi) >> 30;
      term = phi;
      s    = phi;
      for (int j = 1; j <= 10; j++) begin
        term = ((term * p2) >> 30) / 64'((2 * j) * (2 * j + 1));
        if (j[0]) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
      if (s > (64'd1 << 30)) begin
        s = 64'd1 << 30;
      end
      tbl[k] = curve_t'((s * s + (64'd1 << (59 - CURVE_BITS))) >> (60 - CURVE_BITS));
    end
    return tbl;
  endfunction

  localparam curve_table_t CURVE_TABLE = build_curve_table();

endpackage

FILE: rtl/fractal_value_noise_unit.sv
// Fractal value noise unit: nine-stage pipeline, one octave lane per octave.
// Depends on fvn_pkg for widths, hash constants and the blend curve table.
//
// A request accepted at a clock edge passes the stage registers 1 to 9 in order; its
// result shows on out_valid / out_noise_value for one cycle. Throughput:
// one request per cycle, sustained; busy never rises because no stage ever waits.
// Reset (rst_n low, synchronous): clear all stage valid bits and load
// octave_count with 6. Data registers keep whatever they hold.
module fractal_value_noise_unit #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [fvn_pkg::COORD_W-1:0]   in_x_coord,
  input  logic signed [fvn_pkg::COORD_W-1:0]   in_y_coord,
  input  logic        [fvn_pkg::SEED_W-1:0]    in_noise_seed,
  // result channel
  output logic                                 out_valid,
  output logic        [fvn_pkg::OUT_W-1:0]     out_noise_value,
  // octave count register write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [fvn_pkg::CFG_W-1:0]     cfg_octave_count
);

  localparam int NO      = MAX_OCTAVES;
  localparam int PAIRS   = (MAX_OCTAVES + 1) / 2;
  localparam int ACC_W   = fvn_pkg::SMOOTH_W + MAX_OCTAVES + 1;
  localparam int BLEND_W = fvn_pkg::SMOOTH_W + fvn_pkg::CURVE_BITS + 2;
  localparam int NPT     = fvn_pkg::LATTICE_PTS;

  // (a*(1-f) + b*f), truncated
  function automatic fvn_pkg::smooth_t blend(fvn_pkg::smooth_t a, fvn_pkg::smooth_t b,
                                             fvn_pkg::curve_t f);
    logic [BLEND_W-1:0] p;
    fvn_pkg::curve_t    one;
    one = fvn_pkg::curve_t'(1) << fvn_pkg::CURVE_BITS;
    p = BLEND_W'(a) * BLEND_W'(one - f) + BLEND_W'(b) * BLEND_W'(f);
    return p[fvn_pkg::CURVE_BITS +: fvn_pkg::SMOOTH_W];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration: always ready, the register is sampled per request at stage 1.
  // ---------------------------------------------------------------------------
  logic [fvn_pkg::CFG_W-1:0] octave_count_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= fvn_pkg::OCTAVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      octave_count_r <= cfg_octave_count;
    end
  end

  // Valid bits for stages 1..8; stage 9 is the output register.
  logic [8:1] v_r;
  logic       out_valid_r;
  logic       accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= {v_r[7:1], accept};
      out_valid_r <= v_r[8];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the request and turn the clamped octave count into a lane mask.
  // ---------------------------------------------------------------------------
  logic signed [fvn_pkg::COORD_W-1:0] x1_r, y1_r;
  logic        [fvn_pkg::SEED_W-1:0]  seed1_r;
  logic        [NO-1:0]               mask1_r, mask_nxt;
  logic        [fvn_pkg::CFG_W-1:0]   count_clamped;

  always_comb begin
    count_clamped = (octave_count_r > fvn_pkg::CFG_W'(MAX_OCTAVES)) ?
                    fvn_pkg::CFG_W'(MAX_OCTAVES) : octave_count_r;
    for (int o = 0; o < NO; o++) begin
      mask_nxt[o] = (fvn_pkg::CFG_W'(o) < count_clamped);
    end
  end

  always_ff @(posedge clk) begin
    x1_r    <= in_x_coord;
    y1_r    <= in_y_coord;
    seed1_r <= in_noise_seed;
    mask1_r <= mask_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale by 2^o, split floor / fraction, premultiply the lattice
  // coordinates and the seed, and look up the blend weights.
  // ---------------------------------------------------------------------------
  fvn_pkg::hash_t  ixc_nxt [NO];
  fvn_pkg::hash_t  iyc_nxt [NO];
  fvn_pkg::curve_t fx_nxt  [NO];
  fvn_pkg::curve_t fy_nxt  [NO];

  always_comb begin
    logic signed [63:0]                       sx, sy;
    logic        [fvn_pkg::HASH_W-1:0]        ix, iy;
    logic        [fvn_pkg::CURVE_TABLE_BITS-1:0] kx, ky;
    for (int o = 0; o < NO; o++) begin
      sx = 64'(x1_r) <<< o;
      sy = 64'(y1_r) <<< o;
      ix = sx[fvn_pkg::COORD_FRAC_BITS +: fvn_pkg::HASH_W];
      iy = sy[fvn_pkg::COORD_FRAC_BITS +: fvn_pkg::HASH_W];
      kx = sx[fvn_pkg::COORD_FRAC_BITS-1 -: fvn_pkg::CURVE_TABLE_BITS];
      ky = sy[fvn_pkg::COORD_FRAC_BITS-1 -: fvn_pkg::CURVE_TABLE_BITS];
      ixc_nxt[o] = ix * fvn_pkg::HASH_X;
      iyc_nxt[o] = iy * fvn_pkg::HASH_Y;
      fx_nxt[o]  = fvn_pkg::CURVE_TABLE[kx];
      fy_nxt[o]  = fvn_pkg::CURVE_TABLE[ky];
    end
  end

  fvn_pkg::hash_t  ixc2_r [NO];
  fvn_pkg::hash_t  iyc2_r [NO];
  fvn_pkg::hash_t  seedc2_r;
  fvn_pkg::curve_t fx2_r [NO], fx3_r [NO], fx4_r [NO], fx5_r [NO];
  fvn_pkg::curve_t fy2_r [NO], fy3_r [NO], fy4_r [NO], fy5_r [NO], fy6_r [NO];
  logic [NO-1:0]   mask2_r, mask3_r, mask4_r, mask5_r, mask6_r;

  always_ff @(posedge clk) begin
    seedc2_r <= seed1_r * fvn_pkg::HASH_S;
    mask2_r  <= mask1_r;
    for (int o = 0; o < NO; o++) begin
      ixc2_r[o] <= ixc_nxt[o];
      iyc2_r[o] <= iyc_nxt[o];
      fx2_r[o]  <= fx_nxt[o];
      fy2_r[o]  <= fy_nxt[o];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum the 4x4 neighborhood hashes (neighbors are constant offsets of
  // the premultiplied center, wrapping mod 2^32) and apply the xor-shift.
  // ---------------------------------------------------------------------------
  fvn_pkg::hash_t n3_r [NO][NPT];

  always_ff @(posedge clk) begin
    fvn_pkg::hash_t s;
    for (int o = 0; o < NO; o++) begin
      for (int p = 0; p < NPT; p++) begin
        s = ixc2_r[o] + fvn_pkg::HASH_X * fvn_pkg::HASH_W'(p % 4) - fvn_pkg::HASH_X
          + iyc2_r[o] + fvn_pkg::HASH_Y * fvn_pkg::HASH_W'(p / 4) - fvn_pkg::HASH_Y
          + seedc2_r;
        n3_r[o][p] <= s ^ (s >> fvn_pkg::HASH_XSHIFT);
      end
      fx3_r[o] <= fx2_r[o];
      fy3_r[o] <= fy2_r[o];
    end
    mask3_r <= mask2_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: final hash multiply; keep 16 bits from bit 30 down of the 32-bit hash.
  // ---------------------------------------------------------------------------
  fvn_pkg::value_t h4_r [NO][NPT];

  always_ff @(posedge clk) begin
    fvn_pkg::hash_t m;
    for (int o = 0; o < NO; o++) begin
      for (int p = 0; p < NPT; p++) begin
        m = n3_r[o][p] * fvn_pkg::HASH_M;
        h4_r[o][p] <= m[30 -: fvn_pkg::VALUE_BITS];
      end
      fx4_r[o] <= fx3_r[o];
      fy4_r[o] <= fy3_r[o];
    end
    mask4_r <= mask3_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: 1-2-1 smoothing kernel around the four cell corners.
  // ---------------------------------------------------------------------------
  fvn_pkg::smooth_t sm5_r [NO][4];

  always_ff @(posedge clk) begin
    int cy, cx;
    for (int o = 0; o < NO; o++) begin
      for (int c = 0; c < 4; c++) begin
        cy = 1 + (c / 2);
        cx = 1 + (c % 2);
        sm5_r[o][c] <=
            fvn_pkg::SMOOTH_W'(h4_r[o][(cy-1)*4 + cx-1])
          + fvn_pkg::SMOOTH_W'(h4_r[o][(cy-1)*4 + cx+1])
          + fvn_pkg::SMOOTH_W'(h4_r[o][(cy+1)*4 + cx-1])
          + fvn_pkg::SMOOTH_W'(h4_r[o][(cy+1)*4 + cx+1])
          + ((fvn_pkg::SMOOTH_W'(h4_r[o][cy*4 + cx-1])
            + fvn_pkg::SMOOTH_W'(h4_r[o][cy*4 + cx+1])
            + fvn_pkg::SMOOTH_W'(h4_r[o][(cy-1)*4 + cx])
            + fvn_pkg::SMOOTH_W'(h4_r[o][(cy+1)*4 + cx]))
            << 1)
          + (fvn_pkg::SMOOTH_W'(h4_r[o][cy*4 + cx]) << 2);
      end
      fx5_r[o] <= fx4_r[o];
      fy5_r[o] <= fy4_r[o];
    end
    mask5_r <= mask4_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: blend along x (top row, bottom row). Stage 7: blend along y, drop
  // lanes above the octave count.
  // ---------------------------------------------------------------------------
  fvn_pkg::smooth_t bx6_r [NO][2];
  fvn_pkg::smooth_t r7_r  [NO];

  always_ff @(posedge clk) begin
    for (int o = 0; o < NO; o++) begin
      bx6_r[o][0] <= blend(sm5_r[o][0], sm5_r[o][1], fx5_r[o]);
      bx6_r[o][1] <= blend(sm5_r[o][2], sm5_r[o][3], fx5_r[o]);
      fy6_r[o]    <= fy5_r[o];
      r7_r[o]     <= mask6_r[o] ? blend(bx6_r[o][0], bx6_r[o][1], fy6_r[o]) : '0;
    end
    mask6_r <= mask5_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: weight each octave 2^-o and add in pairs. Stage 9: total and truncate.
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0] pair8_r [PAIRS];
  logic [ACC_W-1:0] total;
  logic [fvn_pkg::OUT_W-1:0] out_noise_value_r;

  always_ff @(posedge clk) begin
    for (int p = 0; p < PAIRS; p++) begin
      if (2 * p + 1 < NO) begin
        pair8_r[p] <= (ACC_W'(r7_r[2*p]) << (MAX_OCTAVES - 2*p))
                    + (ACC_W'(r7_r[2*p+1]) << (MAX_OCTAVES - 2*p - 1));
      end else begin
        pair8_r[p] <= ACC_W'(r7_r[2*p]) << (MAX_OCTAVES - 2*p);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int p = 0; p < PAIRS; p++) begin
      total = total + pair8_r[p];
    end
  end

  always_ff @(posedge clk) begin
    out_noise_value_r <= total[MAX_OCTAVES + 4 +: fvn_pkg::OUT_W];
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(v_r[8])) && (v_r[2] == $past(v_r[1])))
    else $error("valid bit lost or invented in pipeline");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> octave_count_r == $past(cfg_octave_count))
    else $error("octave count write not taken");

  a_mask_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> ((mask1_r & (mask1_r + NO'(1))) == '0))
    else $error("octave lane mask not a low-order run of ones");

  a_zero_octaves: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && mask1_r == '0 |-> ##8 (out_noise_value == '0))
    else $error("zero octaves must give zero noise");

endmodule

FILE: tb/sv/fractal_value_noise_unit_checker.sv
// Checker for the fractal value noise unit: watches request, result and
// octave-count write channels, predicts each noise sample and compares it.
// Depends on fvn_pkg for widths and the hash constants.
module fractal_value_noise_unit_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [fvn_pkg::COORD_W-1:0]  in_x_coord,
  input  logic signed [fvn_pkg::COORD_W-1:0]  in_y_coord,
  input  logic        [fvn_pkg::SEED_W-1:0]   in_noise_seed,
  input  logic                                out_valid,
  input  logic        [fvn_pkg::OUT_W-1:0]    out_noise_value,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic        [fvn_pkg::CFG_W-1:0]    cfg_octave_count,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  sample_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fvn_pkg::*;

  localparam int OCTAVE_LIMIT = 8;

  logic [CFG_W-1:0]  octaves_set;
  logic [OUT_W-1:0]  noise_queue[$];
  logic [63:0]       blend_curve[CURVE_ENTRIES];

  // sin^2 quarter-period table, Q30 series rounded to the curve width
  function automatic logic [63:0] curve_at(int k);
    logic [63:0] phi, p2, term, s;
    phi  = (HALF_PI_Q30 * 64'(k)) >> CURVE_TABLE_BITS;
    p2   = (phi * phi) >> 30;
    term = phi;
    s    = phi;
    for (int j = 1; j <= 10; j++) begin
      term = ((term * p2) >> 30) / 64'((2 * j) * (2 * j + 1));
      if (j % 2 == 1) s = s - term;
      else s = s + term;
    end
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    return (s * s + (64'd1 << (59 - CURVE_BITS))) >> (60 - CURVE_BITS);
  endfunction

  function automatic logic [63:0] lattice_hash(logic [31:0] xi, logic [31:0] yi,
                                               logic [31:0] seed);
    logic [31:0] n;
    n = xi * HASH_X + yi * HASH_Y + seed * HASH_S;
    n = (n ^ (n >> HASH_XSHIFT)) * HASH_M;
    return 64'(n[30:31-VALUE_BITS]);
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] f);
    return (a * ((64'd1 << CURVE_BITS) - f) + b * f) >> CURVE_BITS;
  endfunction

  function automatic logic [OUT_W-1:0] noise_sample(logic signed [COORD_W-1:0] xc,
                                                    logic signed [COORD_W-1:0] yc,
                                                    logic [31:0] seed,
                                                    logic [CFG_W-1:0] octs);
    logic signed [63:0] sx, sy, ix, iy;
    logic [63:0] h[4][4];
    logic [63:0] sm[2][2];
    logic [63:0] fx, fy, acc;
    int cnt;
    acc = 0;
    cnt = (octs > OCTAVE_LIMIT) ? OCTAVE_LIMIT : int'(octs);
    for (int i = 0; i < cnt; i++) begin
      sx = 64'(xc) <<< i;
      sy = 64'(yc) <<< i;
      ix = sx >>> COORD_FRAC_BITS;
      iy = sy >>> COORD_FRAC_BITS;
      fx = blend_curve[sx[COORD_FRAC_BITS-1 -: CURVE_TABLE_BITS]];
      fy = blend_curve[sy[COORD_FRAC_BITS-1 -: CURVE_TABLE_BITS]];
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++)
          h[a][b] = lattice_hash(32'(ix + b - 1), 32'(iy + a - 1), seed);
      for (int cy = 1; cy <= 2; cy++)
        for (int cx = 1; cx <= 2; cx++)
          sm[cy-1][cx-1] = h[cy-1][cx-1] + h[cy-1][cx+1] + h[cy+1][cx-1] + h[cy+1][cx+1]
                         + 2 * (h[cy][cx-1] + h[cy][cx+1] + h[cy-1][cx] + h[cy+1][cx])
                         + 4 * h[cy][cx];
      acc += mix(mix(sm[0][0], sm[0][1], fx), mix(sm[1][0], sm[1][1], fx), fy)
             << (OCTAVE_LIMIT - i);
    end
    return OUT_W'(acc >> (OCTAVE_LIMIT + 4));
  endfunction

  initial begin
    for (int k = 0; k < CURVE_ENTRIES; k++) blend_curve[k] = curve_at(k);
    fail_count = 0;
    sample_count = 0;
  end

  assign pending_count = noise_queue.size();

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      octaves_set <= OCTAVE_RESET;
    end else begin
      if (out_valid) begin
        if (noise_queue.size() == 0) begin
          $error("noise_value: unexpected result %0h", out_noise_value);
          fail_count++;
        end else begin
          want = noise_queue.pop_front();
          sample_count++;
          if (out_noise_value !== want) begin
            $error("noise_value: expected %0h actual %0h", want, out_noise_value);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        noise_queue = {noise_queue, noise_sample(in_x_coord, in_y_coord, in_noise_seed,
                                                 octaves_set)};
      if (cfg_valid && cfg_ready) octaves_set <= cfg_octave_count;
    end
  end
endmodule

FILE: tb/sv/fractal_value_noise_unit_test.sv
// Testbench top for the fractal value noise unit: drives requests and octave
// count writes, and gives the verdict. Depends on fvn_pkg and the checker.
module fractal_value_noise_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fvn_pkg::*;

  localparam int LATENCY = 9;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [COORD_W-1:0] in_x_coord = '0;
  logic signed [COORD_W-1:0] in_y_coord = '0;
  logic [SEED_W-1:0] in_noise_seed = '0;
  logic out_valid;
  logic [OUT_W-1:0] out_noise_value;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_octave_count = '0;
  int fail_count, pending_count, sample_count;

  always #1 clk = ~clk;

  fractal_value_noise_unit DUT (.*);

  fractal_value_noise_unit_checker checker_i (.*);

  // Hold off a random number of cycles: mostly none or short, a few long.
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one request and hold it until accepted; start stays high after.
  task automatic send_request(logic signed [COORD_W-1:0] xc,
                              logic signed [COORD_W-1:0] yc, logic [SEED_W-1:0] seed);
    start <= 1;
    in_x_coord <= xc;
    in_y_coord <= yc;
    in_noise_seed <= seed;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain the pipeline, then write the octave count while idle.
  task automatic set_octaves(logic [CFG_W-1:0] octs);
    start <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_valid <= 1;
    cfg_octave_count <= octs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'({$urandom, $urandom});
      1: return COORD_W'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return {{(COORD_W-8){$urandom_range(0, 1) == 1}}, 8'($urandom)};
      default: return {1'b0, 39'({$urandom, $urandom})} | {$urandom_range(0, 1) == 1, 39'd0};
    endcase
  endfunction

  logic signed [COORD_W-1:0] coord_max = {1'b0, {(COORD_W-1){1'b1}}};
  logic signed [COORD_W-1:0] coord_min = {1'b1, {(COORD_W-1){1'b0}}};
  logic [CFG_W-1:0] octave_plan[7] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, lattice wrap near the coordinate limits, and
    // fractions at the curve ends, at the reset octave count.
    send_request('0, '0, '0);
    send_request(coord_max, coord_max, '1);
    send_request(coord_min, coord_min, '1);
    send_request(coord_max, coord_min, 32'h5555_5555);
    send_request(-40'sd1, -40'sd1, 32'hAAAA_AAAA);
    send_request(40'sh0_0000_FFFF, 40'sh0_0001_0000, 32'h1);
    send_request(40'sh0_7FFF_FFFF, -40'sh0_8000_0000, 32'h8000_0000);
    send_request(40'sh0_0000_8000, 40'sh0_0000_0080, 32'd12345);
    // Zero octaves, too many octaves and the extremes of the range.
    foreach (octave_plan[p]) begin
      set_octaves(octave_plan[p]);
      send_request(coord_max, coord_min, '1);
      send_request(-40'sd1, 40'sd1, 32'hDEAD_BEEF);
    end

    // Random part: several octave settings, back-to-back bursts and gaps.
    for (int ph = 0; ph < 6; ph++) begin
      set_octaves(ph == 0 ? 4'd8 : ph == 1 ? 4'd1 : 4'($urandom));
      for (int k = 0; k < 72; k++) begin
        send_request(rand_coord(), rand_coord(), $urandom);
        if (k == 36) begin
          // Pause until every outstanding result is back, once per phase.
          start <= 0;
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end else if ($urandom_range(0, 3) != 0) begin
          idle_gap();
        end
      end
    end

    start <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Covered %0d noise samples across octave counts 0 to 15, with lattice wrap",
             sample_count);
    $display("and coordinate extremes, bursts and idle gaps.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: sim.f
rtl/fvn_pkg.sv
rtl/fractal_value_noise_unit.sv
tb/sv/fractal_value_noise_unit_checker.sv
tb/sv/fractal_value_noise_unit_test.sv
